### rtl/core/hgl_pkg.sv
// Shared types and constants for the hybrid gshare/local branch predictor.
`timescale 1ns / 1ps

package hgl_pkg;

  localparam int ADDR_W = 32;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] CTR_BITS_RESET = 4'd2;

  // Chooser record codes: bit 0 is gshare right, bit 1 is local right.
  localparam logic [1:0] REC_NONE   = 2'd0;
  localparam logic [1:0] REC_GSHARE = 2'd1;
  localparam logic [1:0] REC_LOCAL  = 2'd2;
  localparam logic [1:0] REC_BOTH   = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } item_t;

  typedef struct packed {
    logic       gshare_prediction;
    logic       local_prediction;
    logic       gshare_correct;
    logic       local_correct;
    logic       gshare_miss_counted;
    logic       local_miss_counted;
    logic [1:0] prior_record;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

endpackage

### rtl/core/hgl_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module hgl_ram #(
  parameter int AW = 15,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/hgl_sat_ctr.sv
// Saturating counter direction and next value for a run-time counter width.
`timescale 1ns / 1ps

module hgl_sat_ctr #(
  parameter int MAX_COUNTER_BITS = 8
) (
  input  logic [MAX_COUNTER_BITS-1:0] value,
  input  logic                        taken,
  input  logic [hgl_pkg::CFG_W-1:0]   width,
  output logic                        pred,
  output logic [MAX_COUNTER_BITS-1:0] value_next
);

  logic [MAX_COUNTER_BITS-1:0] half;
  logic [MAX_COUNTER_BITS-1:0] top;

  assign half = MAX_COUNTER_BITS'(1) << (width - hgl_pkg::CFG_W'(1));
  assign top  = ~({MAX_COUNTER_BITS{1'b1}} << width);
  assign pred = (value >= half);

  // A counter left above the top by a lowered width holds on taken.
  always_comb begin
    value_next = value;
    if (taken) begin
      if (value < top) begin
        value_next = value + MAX_COUNTER_BITS'(1);
      end
    end else if (value != '0) begin
      value_next = value - MAX_COUNTER_BITS'(1);
    end
  end

endmodule

### rtl/core/hybrid_gshare_local_branch_predictor_core.sv
// Top level of the hybrid gshare/local branch predictor with its table control.
//
//   Channel   Signals                              Word
//   --------  -----------------------------------  ------------------------------
//   item      item_valid, item_ready, item         resolved branch (address, taken)
//   result    result_valid, result_ready, result   both predictions and scoring
//   config    cfg_we, cfg_wdata                    counter width, 4 bits
//
// Each word passes through lookup and update: the address-indexed table reads
// are issued as it is taken, the local counter read that depends on the local
// history just read in lookup, then the update, where the next word may be taken.
// After reset a clearing pass zeroes the tables, during which item_ready stays low.
// A held result stalls the update cycle; item_ready then stays low as well.
`timescale 1ns / 1ps

module hybrid_gshare_local_branch_predictor_core #(
  parameter int INDEX_BITS       = 15,
  parameter int LOCAL_INDEX_BITS = 15,
  parameter int MAX_COUNTER_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  hgl_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output hgl_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [hgl_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IB  = INDEX_BITS;
  localparam int LIB = LOCAL_INDEX_BITS;
  localparam int CB  = MAX_COUNTER_BITS;
  localparam int CLR_W = (IB > LIB) ? IB : LIB;

  hgl_pkg::state_t state, state_next;

  logic [hgl_pkg::CFG_W-1:0] counter_bits;
  logic [hgl_pkg::CFG_W-1:0] width;
  logic [CLR_W-1:0]          clr_addr;
  logic [IB-1:0]             ghist;
  logic [IB-1:0]             ghist_upd;
  logic [IB-1:0]             ghist_eff;

  // Item being worked on.
  logic [IB-1:0]  gidx_q;
  logic [IB-1:0]  ridx_q;
  logic [LIB-1:0] lsel_q;
  logic           taken_q;
  logic [CB-1:0]  gctr_q;
  logic [1:0]     rec_q;
  logic [IB-1:0]  lhist_q;

  // Last table write, forwarded to a read issued in the same cycle.
  logic           byp_valid;
  logic [IB-1:0]  byp_gidx;
  logic [CB-1:0]  byp_gctr;
  logic [IB-1:0]  byp_ridx;
  logic [1:0]     byp_rec;
  logic [LIB-1:0] byp_lsel;
  logic [IB-1:0]  byp_lhist;

  logic           accept;
  logic           slot_free;
  logic           fire;
  logic           lookup_re;
  logic           clearing;

  logic [CB-1:0]  gctr_rd;
  logic [1:0]     rec_rd;
  logic [IB-1:0]  lhist_rd;
  logic [CB-1:0]  lctr_rd;
  logic [CB-1:0]  gctr_fwd;
  logic [1:0]     rec_fwd;
  logic [IB-1:0]  lhist_fwd;

  logic           gpred;
  logic           lpred;
  logic [CB-1:0]  gctr_new;
  logic [CB-1:0]  lctr_new;
  logic           gc;
  logic           lc;
  logic           unsure;
  logic [1:0]     rec_new;
  logic [IB-1:0]  lhist_new;

  logic           tab_we;
  logic [IB-1:0]  gctr_waddr;
  logic [CB-1:0]  gctr_wdata;
  logic [IB-1:0]  lctr_waddr;
  logic [CB-1:0]  lctr_wdata;
  logic [IB-1:0]  rec_waddr;
  logic [1:0]     rec_wdata;
  logic [LIB-1:0] lhist_waddr;
  logic [IB-1:0]  lhist_wdata;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      hgl_pkg::ST_CLEAR: begin
        if (&clr_addr) begin
          state_next = hgl_pkg::ST_IDLE;
        end
      end
      hgl_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = hgl_pkg::ST_LOOKUP;
        end
      end
      hgl_pkg::ST_LOOKUP: begin
        state_next = hgl_pkg::ST_UPDATE;
      end
      hgl_pkg::ST_UPDATE: begin
        if (slot_free) begin
          state_next = item_valid ? hgl_pkg::ST_LOOKUP : hgl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hgl_pkg::ST_CLEAR;
      end
    endcase
  end

  assign slot_free = !result_valid || result_ready;

  // Control outputs.
  always_comb begin
    item_ready = 1'b0;
    fire       = 1'b0;
    lookup_re  = 1'b0;
    clearing   = 1'b0;
    case (state)
      hgl_pkg::ST_CLEAR: begin
        clearing = 1'b1;
      end
      hgl_pkg::ST_IDLE: begin
        item_ready = 1'b1;
      end
      hgl_pkg::ST_LOOKUP: begin
        lookup_re = 1'b1;
      end
      hgl_pkg::ST_UPDATE: begin
        fire       = slot_free;
        item_ready = slot_free;
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  assign accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hgl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_bits <= hgl_pkg::CTR_BITS_RESET;
    end else if (cfg_we) begin
      counter_bits <= cfg_wdata;
    end
  end

  always_comb begin
    if (counter_bits == '0) begin
      width = hgl_pkg::CFG_W'(1);
    end else if (counter_bits > hgl_pkg::CFG_W'(CB)) begin
      width = hgl_pkg::CFG_W'(CB);
    end else begin
      width = counter_bits;
    end
  end

  // The next item may be taken in the update cycle, so it sees the new history.
  assign ghist_upd = {ghist[IB-2:0], taken_q};
  assign ghist_eff = fire ? ghist_upd : ghist;

  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
    end else if (fire) begin
      ghist <= ghist_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gidx_q  <= item.branch_address[IB-1:0] ^ ghist_eff;
      ridx_q  <= item.branch_address[IB-1:0];
      lsel_q  <= item.branch_address[LIB-1:0];
      taken_q <= item.taken;
    end
  end

  // Tables.
  hgl_ram #(.AW(IB), .DW(CB)) u_gctr_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (gctr_waddr),
    .wdata (gctr_wdata),
    .re    (accept),
    .raddr (item.branch_address[IB-1:0] ^ ghist_eff),
    .rdata (gctr_rd)
  );

  hgl_ram #(.AW(IB), .DW(2)) u_rec_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .re    (accept),
    .raddr (item.branch_address[IB-1:0]),
    .rdata (rec_rd)
  );

  hgl_ram #(.AW(LIB), .DW(IB)) u_lhist_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (lhist_waddr),
    .wdata (lhist_wdata),
    .re    (accept),
    .raddr (item.branch_address[LIB-1:0]),
    .rdata (lhist_rd)
  );

  hgl_ram #(.AW(IB), .DW(CB)) u_lctr_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (lctr_waddr),
    .wdata (lctr_wdata),
    .re    (lookup_re),
    .raddr (lhist_fwd),
    .rdata (lctr_rd)
  );

  // A read issued on the edge of the previous write returns stale data; the
  // bypass holds the latest update write, so using it on a match is safe.
  assign gctr_fwd  = (byp_valid && byp_gidx == gidx_q) ? byp_gctr : gctr_rd;
  assign rec_fwd   = (byp_valid && byp_ridx == ridx_q) ? byp_rec : rec_rd;
  assign lhist_fwd = (byp_valid && byp_lsel == lsel_q) ? byp_lhist : lhist_rd;

  always_ff @(posedge clk) begin
    if (lookup_re) begin
      gctr_q  <= gctr_fwd;
      rec_q   <= rec_fwd;
      lhist_q <= lhist_fwd;
    end
  end

  // Update.
  hgl_sat_ctr #(.MAX_COUNTER_BITS(CB)) u_gshare_ctr (
    .value      (gctr_q),
    .taken      (taken_q),
    .width      (width),
    .pred       (gpred),
    .value_next (gctr_new)
  );

  hgl_sat_ctr #(.MAX_COUNTER_BITS(CB)) u_local_ctr (
    .value      (lctr_rd),
    .taken      (taken_q),
    .width      (width),
    .pred       (lpred),
    .value_next (lctr_new)
  );

  assign gc        = (gpred == taken_q);
  assign lc        = (lpred == taken_q);
  assign unsure    = (rec_q == hgl_pkg::REC_NONE) || (rec_q == hgl_pkg::REC_BOTH);
  assign rec_new   = {lc, gc};
  assign lhist_new = {lhist_q[IB-2:0], taken_q};

  assign tab_we = clearing || fire;

  always_comb begin
    if (clearing) begin
      gctr_waddr  = clr_addr[IB-1:0];
      gctr_wdata  = '0;
      lctr_waddr  = clr_addr[IB-1:0];
      lctr_wdata  = '0;
      rec_waddr   = clr_addr[IB-1:0];
      rec_wdata   = hgl_pkg::REC_NONE;
      lhist_waddr = clr_addr[LIB-1:0];
      lhist_wdata = '0;
    end else begin
      gctr_waddr  = gidx_q;
      gctr_wdata  = gctr_new;
      lctr_waddr  = lhist_q;
      lctr_wdata  = lctr_new;
      rec_waddr   = ridx_q;
      rec_wdata   = rec_new;
      lhist_waddr = lsel_q;
      lhist_wdata = lhist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (clearing) begin
      byp_valid <= 1'b0;
    end else if (fire) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byp_gidx  <= gidx_q;
      byp_gctr  <= gctr_new;
      byp_ridx  <= ridx_q;
      byp_rec   <= rec_new;
      byp_lsel  <= lsel_q;
      byp_lhist <= lhist_new;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.gshare_prediction   <= gpred;
      result.local_prediction    <= lpred;
      result.gshare_correct      <= gc;
      result.local_correct       <= lc;
      result.gshare_miss_counted <= !gc && unsure;
      result.local_miss_counted  <= !lc && unsure;
      result.prior_record        <= rec_q;
    end
  end

`ifndef SYNTH
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == hgl_pkg::ST_LOOKUP))
    else $error("accepted word did not enter lookup");

  a_lookup_to_update: assert property (@(posedge clk) disable iff (rst)
    (state == hgl_pkg::ST_LOOKUP) |=> (state == hgl_pkg::ST_UPDATE))
    else $error("lookup not followed by update");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == hgl_pkg::ST_CLEAR) |-> !item_ready)
    else $error("word accepted during table clear");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == hgl_pkg::ST_UPDATE))
    else $error("result raised outside update");

  a_stall_holds_update: assert property (@(posedge clk) disable iff (rst)
    ((state == hgl_pkg::ST_UPDATE) && !slot_free) |=>
      ((state == hgl_pkg::ST_UPDATE) && $stable(gidx_q) && $stable(lhist_q)))
    else $error("stalled update lost its word");
`endif

endmodule

### bench/hybrid_gshare_local_branch_predictor_core_tb.sv
// Self-checking testbench for the hybrid gshare/local branch predictor core.
`timescale 1ns / 1ps

module hybrid_gshare_local_branch_predictor_core_tb;

  localparam int IDX_W          = 15;
  localparam int TAB_DEPTH      = 1 << IDX_W;
  localparam int CTR_MAX_W      = 8;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int REPORT_LIMIT   = 10;

  logic                      clk;
  logic                      rst;
  logic                      item_valid;
  logic                      item_ready;
  hgl_pkg::item_t            item;
  logic                      result_valid;
  logic                      result_ready;
  hgl_pkg::result_t          result;
  logic                      cfg_we;
  logic [hgl_pkg::CFG_W-1:0] cfg_wdata;

  // Our own copy of the predictor tables and the width register.
  logic [hgl_pkg::CFG_W-1:0] width_reg;
  logic [IDX_W-1:0]          ghist;
  logic [CTR_MAX_W-1:0]      gshare_ctr_tab [TAB_DEPTH];
  logic [IDX_W-1:0]          local_hist_tab [TAB_DEPTH];
  logic [CTR_MAX_W-1:0]      local_ctr_tab  [TAB_DEPTH];
  logic [1:0]                chooser_tab    [TAB_DEPTH];

  hgl_pkg::result_t pending_scores[$];

  bit calm;
  int branches_sent;
  int results_seen;
  int mismatches;
  int quiet_cycles;
  int gshare_misses;
  int local_misses;
  int record_hits [4];
  logic [15:0] widths_written;

  hybrid_gshare_local_branch_predictor_core #(
    .INDEX_BITS      (IDX_W),
    .LOCAL_INDEX_BITS(IDX_W),
    .MAX_COUNTER_BITS(CTR_MAX_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_width();
    int unsigned n;
    n = width_reg;
    if (n < 1) n = 1;
    if (n > CTR_MAX_W) n = CTR_MAX_W;
    return n;
  endfunction

  function automatic logic ctr_says_taken(input logic [CTR_MAX_W-1:0] v, input int unsigned n);
    return {1'b0, v} >= 9'(1 << (n - 1));
  endfunction

  // Saturates at zero and at the top of the current width; a counter left above
  // the top by a narrowed width only moves down.
  function automatic logic [CTR_MAX_W-1:0] step_counter(input logic [CTR_MAX_W-1:0] v,
                                                        input logic tk, input int unsigned n);
    logic [CTR_MAX_W:0] top;
    top = 9'((1 << n) - 1);
    if (tk) begin
      return ({1'b0, v} < top) ? v + 1'b1 : v;
    end
    return (v != '0) ? v - 1'b1 : v;
  endfunction

  function automatic hgl_pkg::result_t score_branch(input logic [hgl_pkg::ADDR_W-1:0] pc,
                                                    input logic tk);
    hgl_pkg::result_t r;
    int unsigned n;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] gidx;
    logic [IDX_W-1:0] lidx;
    logic [1:0] rec;
    logic unsure;
    n = active_width();
    slot = pc[IDX_W-1:0];
    gidx = slot ^ ghist;
    lidx = local_hist_tab[slot];
    rec = chooser_tab[slot];
    r.gshare_prediction = ctr_says_taken(gshare_ctr_tab[gidx], n);
    r.local_prediction = ctr_says_taken(local_ctr_tab[lidx], n);
    gshare_ctr_tab[gidx] = step_counter(gshare_ctr_tab[gidx], tk, n);
    local_ctr_tab[lidx] = step_counter(local_ctr_tab[lidx], tk, n);
    r.gshare_correct = (r.gshare_prediction == tk);
    r.local_correct = (r.local_prediction == tk);
    unsure = (rec == hgl_pkg::REC_NONE) || (rec == hgl_pkg::REC_BOTH);
    r.gshare_miss_counted = !r.gshare_correct && unsure;
    r.local_miss_counted = !r.local_correct && unsure;
    r.prior_record = rec;
    ghist = {ghist[IDX_W-2:0], tk};
    local_hist_tab[slot] = {local_hist_tab[slot][IDX_W-2:0], tk};
    chooser_tab[slot] = {r.local_correct, r.gshare_correct};
    record_hits[rec]++;
    if (r.gshare_miss_counted) gshare_misses++;
    if (r.local_miss_counted) local_misses++;
    return r;
  endfunction

  task automatic clear_tables();
    width_reg = hgl_pkg::CTR_BITS_RESET;
    ghist = '0;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      gshare_ctr_tab[i] = '0;
      local_hist_tab[i] = '0;
      local_ctr_tab[i] = '0;
      chooser_tab[i] = hgl_pkg::REC_NONE;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_branch(input logic [hgl_pkg::ADDR_W-1:0] pc, input logic tk);
    while (!calm && $urandom_range(0, 99) < 7) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{branch_address: pc, taken: tk};
    do @(posedge clk); while (!item_ready);
    pending_scores.push_back(score_branch(pc, tk));
    branches_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_scores.size() != 0) @(negedge clk);
  endtask

  task automatic set_counter_width(input logic [hgl_pkg::CFG_W-1:0] w);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
    widths_written[w] = 1'b1;
  endtask

  // A handful of branch slots that keep coming back, with random upper address bits.
  function automatic logic [hgl_pkg::ADDR_W-1:0] hot_branch();
    logic [IDX_W-1:0] low;
    logic [hgl_pkg::ADDR_W-IDX_W-1:0] high;
    case ($urandom_range(0, 7))
      0: low = 15'h0000;
      1: low = 15'h7FFF;
      2: low = 15'h0123;
      3: low = 15'h2AAA;
      4: low = 15'h5555;
      5: low = 15'h1000;
      6: low = 15'h0F0F;
      default: low = 15'h3C3C;
    endcase
    high = (hgl_pkg::ADDR_W-IDX_W)'($urandom);
    return {high, low};
  endfunction

  // Mostly loop branches and biased branches on hot slots, some random noise.
  task automatic run_mixed_phase(input int count);
    int sent;
    int trip;
    int reps;
    int bias;
    logic [hgl_pkg::ADDR_W-1:0] pc;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_branch($urandom, 1'($urandom));
          sent++;
        end
        2: begin
          pc = hot_branch();
          bias = $urandom_range(50, 95);
          repeat (8) send_branch(pc, $urandom_range(0, 99) < bias);
          sent += 8;
        end
        default: begin
          pc = hot_branch();
          trip = $urandom_range(1, 7);
          reps = $urandom_range(2, 5);
          repeat (reps) begin
            for (int i = 0; i < trip; i++) send_branch(pc, i != trip - 1);
          end
          sent += trip * reps;
        end
      endcase
    end
  endtask

  task automatic test_directed_basics();
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    send_branch(32'h8000_0000, 1'b1);
    send_branch(32'h7FFF_FFFF, 1'b0);
    // One branch is trained taken, then flipped.
    repeat (7) send_branch(32'h0000_1234, 1'b1);
    repeat (4) send_branch(32'h0000_1234, 1'b0);
    send_branch(32'hDEAD_1234, 1'b1);
    send_branch(32'h0000_1234, 1'b1);
  endtask

  task automatic test_width_extremes();
    set_counter_width(4'd0);
    run_mixed_phase(60);
    set_counter_width(4'd1);
    run_mixed_phase(60);
    set_counter_width(4'd8);
    run_mixed_phase(60);
    set_counter_width(4'd15);
    run_mixed_phase(60);
  endtask

  // With every outcome taken both histories settle to all ones, so the same two
  // counters are hit again and again; narrowing the width then leaves them above
  // the top.
  task automatic test_counter_above_max();
    calm = 1'b1;
    set_counter_width(4'd8);
    repeat (45) send_branch(32'h0004_2468, 1'b1);
    set_counter_width(4'd2);
    repeat (3) begin
      repeat (15) send_branch(32'h0004_2468, 1'b1);
      send_branch(32'h0004_2468, 1'b0);
    end
    calm = 1'b0;
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      set_counter_width(4'($urandom_range(0, 15)));
      calm = (p == 3);
      run_mixed_phase(100);
    end
    calm = 1'b0;
  endtask

  task automatic check_score(input hgl_pkg::result_t got, input hgl_pkg::result_t want);
    if (got.gshare_prediction !== want.gshare_prediction ||
        got.local_prediction !== want.local_prediction ||
        got.gshare_correct !== want.gshare_correct ||
        got.local_correct !== want.local_correct ||
        got.gshare_miss_counted !== want.gshare_miss_counted ||
        got.local_miss_counted !== want.local_miss_counted ||
        got.prior_record !== want.prior_record) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result %0d: expected gp=%b lp=%b gc=%b lc=%b gm=%b lm=%b rec=%0d",
                 results_seen, want.gshare_prediction, want.local_prediction,
                 want.gshare_correct, want.local_correct, want.gshare_miss_counted,
                 want.local_miss_counted, want.prior_record);
        $display("           got      gp=%b lp=%b gc=%b lc=%b gm=%b lm=%b rec=%0d",
                 got.gshare_prediction, got.local_prediction, got.gshare_correct,
                 got.local_correct, got.gshare_miss_counted, got.local_miss_counted,
                 got.prior_record);
      end
    end
  endtask

  always @(negedge clk) begin
    result_ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (result_valid && result_ready) begin
      results_seen++;
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("unexpected result word %b", result);
      end else begin
        check_score(result, pending_scores.pop_front());
      end
    end
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    widths_written = '0;
    clear_tables();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_width_extremes();
    test_counter_above_max();
    test_random_phases();

    wait_drained();
    repeat (20) @(negedge clk);
    if (pending_scores.size() != 0) mismatches++;

    $display("Ran %0d branches, checked %0d results, counter widths written: mask %h.",
             branches_sent, results_seen, widths_written);
    $display("Miss flags gshare %0d local %0d; prior records %0d/%0d/%0d/%0d.",
             gshare_misses, local_misses, record_hits[hgl_pkg::REC_NONE],
             record_hits[hgl_pkg::REC_GSHARE], record_hits[hgl_pkg::REC_LOCAL],
             record_hits[hgl_pkg::REC_BOTH]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
